// ===== src/assert_macros.svh =====
// assertion helpers used by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("same-cycle implication failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("next-cycle implication failed");

`endif

// ===== src/lfsa_pkg.sv =====
package lfsa_pkg;

    // slot pool and field widths
    localparam int NUM_SLOTS  = 1024;
    localparam int OWNER_W    = 10;
    localparam int SLOT_OUT_W = 10;
    localparam int ERR_W      = 2;

    // occupancy kept as rows of bits
    localparam int WORD_W    = 32;
    localparam int WBIT_W    = $clog2(WORD_W);
    localparam int NUM_WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int SLOTREF_W = WIDX_W + WBIT_W;
    localparam int OROW_W    = OWNER_W - WBIT_W;
    localparam int OWN_ROWS  = 2 ** OROW_W;
    localparam int NUM_OWNERS = 2 ** OWNER_W;

    // shared find-first-free unit
    localparam int FF_W  = (NUM_WORDS > WORD_W) ? NUM_WORDS : WORD_W;
    localparam int FF_IW = $clog2(FF_W);

    // stream word widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;

    localparam logic OP_LEAVE  = 1'b0;
    localparam logic OP_ARRIVE = 1'b1;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK,
        ERR_FULL,
        ERR_NOT_SEATED,
        ERR_SEATED
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_FIND,
        ST_FREE
    } state_t;

    typedef struct packed {
        logic             found;
        logic [FF_IW-1:0] idx;
    } ffz_res_t;

    // bits of an occupancy row that lie beyond the last slot read as busy
    function automatic logic [WORD_W-1:0] pad_mask(input logic [WIDX_W-1:0] w);
        logic [WORD_W-1:0] m;
        for (int b = 0; b < WORD_W; b++) begin
            m[b] = ((int'(w) * WORD_W + b) >= NUM_SLOTS);
        end
        return m;
    endfunction

endpackage

// ===== src/lfsa_ram.sv =====
module lfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lfsa_ffz.sv =====
module lfsa_ffz (
    input  logic [lfsa_pkg::FF_W-1:0] busy_vec,
    output lfsa_pkg::ffz_res_t        res
);
    import lfsa_pkg::*;

    // lowest clear bit of the vector
    always_comb begin
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = FF_W - 1; i >= 0; i--) begin
            if (!busy_vec[i]) begin
                res.found = 1'b1;
                res.idx   = FF_IW'(i);
            end
        end
    end

endmodule

// ===== src/lowest_free_slot_allocator.sv =====
// lowest free slot allocator
// result: registered from LOOKUP on an error, else from FIND or FREE; both wait on out_free
// words are taken only in IDLE, after the last result is registered; s_tready low meanwhile.
// one find-first-free unit is used twice per arrive: first on the row-full flags,
// then on the chosen occupancy row read from memory.
// reset: all slots free, nobody seated, target 0; row valid flags cleared.
`include "assert_macros.svh"

module lowest_free_slot_allocator (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration: target owner
    input  logic                            cfg_wr_en,
    input  logic [lfsa_pkg::OWNER_W-1:0]    cfg_wr_data,
    // input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lfsa_pkg::S_TDATA_W-1:0]  s_tdata,   // [9:0] owner_id, rest zero
    input  logic [lfsa_pkg::S_TUSER_W-1:0]  s_tuser,   // [0] op
    // result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lfsa_pkg::M_TDATA_W-1:0]  m_tdata,   // [9:0] slot, rest zero
    output logic [lfsa_pkg::M_TUSER_W-1:0]  m_tuser    // [0] is_target, [2:1] error_code
);
    import lfsa_pkg::*;

    state_t                 state_reg, state_next;
    logic                   op_reg, op_next;
    logic [OWNER_W-1:0]     owner_reg, owner_next;
    logic [WIDX_W-1:0]      widx_reg, widx_next;
    logic [OWNER_W-1:0]     target_reg;
    logic [NUM_WORDS-1:0]   full_reg, full_next;
    logic [NUM_WORDS-1:0]   busy_valid_reg, busy_valid_next;
    logic [OWN_ROWS-1:0]    seat_valid_reg, seat_valid_next;

    logic                   m_valid_reg, m_valid_next;
    logic [SLOT_OUT_W-1:0]  m_slot_reg, m_slot_next;
    logic                   m_tgt_reg, m_tgt_next;
    err_t                   m_err_reg, m_err_next;

    // memory ports
    logic                   seat_we, seat_re;
    logic [OROW_W-1:0]      seat_raddr;
    logic [WORD_W-1:0]      seat_wdata, seat_rdata;
    logic                   busy_we, busy_re;
    logic [WIDX_W-1:0]      busy_raddr;
    logic [WORD_W-1:0]      busy_wdata, busy_rdata;
    logic                   oslot_we, oslot_re;
    logic [SLOTREF_W-1:0]   oslot_wdata, oslot_rdata;

    // shared search unit
    logic [FF_W-1:0]        ffz_in;
    ffz_res_t               ffz_res;

    logic                   out_free;
    logic [OROW_W-1:0]      own_row;
    logic [WBIT_W-1:0]      own_bit;
    logic [WORD_W-1:0]      seat_eff, busy_eff;
    logic                   seated;
    logic [WBIT_W-1:0]      free_bit, rel_bit;

    assign out_free = !m_valid_reg || m_tready;
    assign own_row  = owner_reg[OWNER_W-1:WBIT_W];
    assign own_bit  = owner_reg[WBIT_W-1:0];

    // rows never written read as all zero
    assign seat_eff = seat_valid_reg[own_row] ? seat_rdata : '0;
    assign busy_eff = (busy_valid_reg[widx_reg] ? busy_rdata : '0) | pad_mask(widx_reg);
    assign seated   = seat_eff[own_bit];
    assign free_bit = WBIT_W'(ffz_res.idx);
    assign rel_bit  = oslot_rdata[WBIT_W-1:0];

    // search operand: row-full flags, or the chosen occupancy row
    always_comb begin
        ffz_in = '1;
        if (state_reg == ST_FIND) begin
            ffz_in[WORD_W-1:0] = busy_eff;
        end else begin
            ffz_in[NUM_WORDS-1:0] = full_reg;
        end
    end

    lfsa_ffz u_ffz (
        .busy_vec (ffz_in),
        .res      (ffz_res)
    );

    // seated map, one bit per owner
    lfsa_ram #(.WIDTH(WORD_W), .DEPTH(OWN_ROWS)) u_seat_ram (
        .aclk  (aclk),
        .we    (seat_we),
        .waddr (own_row),
        .wdata (seat_wdata),
        .re    (seat_re),
        .raddr (seat_raddr),
        .rdata (seat_rdata)
    );

    // occupancy map, one bit per slot
    lfsa_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_busy_ram (
        .aclk  (aclk),
        .we    (busy_we),
        .waddr (widx_reg),
        .wdata (busy_wdata),
        .re    (busy_re),
        .raddr (busy_raddr),
        .rdata (busy_rdata)
    );

    // slot held by each owner
    lfsa_ram #(.WIDTH(SLOTREF_W), .DEPTH(NUM_OWNERS)) u_oslot_ram (
        .aclk  (aclk),
        .we    (oslot_we),
        .waddr (owner_reg),
        .wdata (oslot_wdata),
        .re    (oslot_re),
        .raddr (s_tdata[OWNER_W-1:0]),
        .rdata (oslot_rdata)
    );

    // sequencer
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        owner_next      = owner_reg;
        widx_next       = widx_reg;
        full_next       = full_reg;
        busy_valid_next = busy_valid_reg;
        seat_valid_next = seat_valid_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_slot_next     = m_slot_reg;
        m_tgt_next      = m_tgt_reg;
        m_err_next      = m_err_reg;
        s_tready        = 1'b0;
        seat_re         = 1'b0;
        seat_raddr      = s_tdata[OWNER_W-1:WBIT_W];
        seat_we         = 1'b0;
        seat_wdata      = seat_eff;
        busy_re         = 1'b0;
        busy_raddr      = WIDX_W'(ffz_res.idx);
        busy_we         = 1'b0;
        busy_wdata      = busy_eff;
        oslot_re        = 1'b0;
        oslot_we        = 1'b0;
        oslot_wdata     = {widx_reg, free_bit};

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next    = s_tuser[0];
                    owner_next = s_tdata[OWNER_W-1:0];
                    seat_re    = 1'b1;
                    oslot_re   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (op_reg == OP_ARRIVE) begin
                    if (seated || !ffz_res.found) begin
                        if (out_free) begin
                            m_valid_next = 1'b1;
                            m_slot_next  = '0;
                            m_tgt_next   = 1'b0;
                            m_err_next   = seated ? ERR_SEATED : ERR_FULL;
                            state_next   = ST_IDLE;
                        end
                    end else begin
                        busy_re    = 1'b1;
                        busy_raddr = WIDX_W'(ffz_res.idx);
                        widx_next  = WIDX_W'(ffz_res.idx);
                        state_next = ST_FIND;
                    end
                end else begin
                    if (!seated) begin
                        if (out_free) begin
                            m_valid_next = 1'b1;
                            m_slot_next  = '0;
                            m_tgt_next   = 1'b0;
                            m_err_next   = ERR_NOT_SEATED;
                            state_next   = ST_IDLE;
                        end
                    end else begin
                        busy_re    = 1'b1;
                        busy_raddr = oslot_rdata[SLOTREF_W-1:WBIT_W];
                        widx_next  = oslot_rdata[SLOTREF_W-1:WBIT_W];
                        state_next = ST_FREE;
                    end
                end
            end
            ST_FIND: begin
                busy_wdata  = busy_eff | (WORD_W'(1) << free_bit);
                seat_wdata  = seat_eff | (WORD_W'(1) << own_bit);
                oslot_wdata = {widx_reg, free_bit};
                if (out_free) begin
                    busy_we                   = 1'b1;
                    seat_we                   = 1'b1;
                    oslot_we                  = 1'b1;
                    busy_valid_next[widx_reg] = 1'b1;
                    seat_valid_next[own_row]  = 1'b1;
                    full_next[widx_reg]       = &busy_wdata;
                    m_valid_next = 1'b1;
                    m_slot_next  = SLOT_OUT_W'({widx_reg, free_bit});
                    m_tgt_next   = (owner_reg == target_reg);
                    m_err_next   = ERR_OK;
                    state_next   = ST_IDLE;
                end
            end
            ST_FREE: begin
                busy_wdata = busy_eff & ~(WORD_W'(1) << rel_bit);
                seat_wdata = seat_eff & ~(WORD_W'(1) << own_bit);
                if (out_free) begin
                    busy_we                   = 1'b1;
                    seat_we                   = 1'b1;
                    busy_valid_next[widx_reg] = 1'b1;
                    seat_valid_next[own_row]  = 1'b1;
                    full_next[widx_reg]       = 1'b0;
                    m_valid_next = 1'b1;
                    m_slot_next  = SLOT_OUT_W'(oslot_rdata);
                    m_tgt_next   = 1'b0;
                    m_err_next   = ERR_OK;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            full_reg       <= '0;
            busy_valid_reg <= '0;
            seat_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
            target_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            full_reg       <= full_next;
            busy_valid_reg <= busy_valid_next;
            seat_valid_reg <= seat_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                target_reg <= cfg_wr_data;
            end
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        owner_reg  <= owner_next;
        widx_reg   <= widx_next;
        m_slot_reg <= m_slot_next;
        m_tgt_reg  <= m_tgt_next;
        m_err_reg  <= m_err_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_slot_reg);
    assign m_tuser  = {m_err_reg, m_tgt_reg};

    // checks
    `ASSERT_IMPL(a_err_not_target, m_valid_reg && (m_err_reg != ERR_OK), !m_tgt_reg)
    `ASSERT_IMPL(a_find_has_free, state_reg == ST_FIND, ffz_res.found)
    `ASSERT_NEXT(a_grant_gives_word, (state_reg == ST_FIND) && out_free, m_valid_reg && (m_err_reg == ERR_OK))
    `ASSERT_IMPL(a_ready_only_idle, s_tready, state_reg == ST_IDLE)

endmodule

// ===== sim/slot_grant_checker.sv =====
`timescale 1ns / 100ps

module slot_grant_checker
    import lfsa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [OWNER_W-1:0]    cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] owner_id, rest zero
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [0] op
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // [9:0] slot, rest zero
    input  logic [M_TUSER_W-1:0]  m_tuser,   // [0] is_target, [2:1] error_code
    output int                    fail_count,
    output int                    outstanding,
    output int                    checked_count,
    output int                    target_grants,
    output int                    error_results,
    output int                    peak_slot
);

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic                  is_target;
        err_t                  code;
    } grant_t;

    // own copy of the allocator state
    bit                 slot_taken [NUM_SLOTS];
    bit                 owner_in   [NUM_OWNERS];
    int                 owner_seat [NUM_OWNERS];
    logic [OWNER_W-1:0] flagged_owner;

    // results still owed by the block, oldest first
    grant_t grants_due[$];

    int fails;
    int checked;
    int flagged_hits;
    int error_hits;
    int top_slot;

    // apply one event to the state and work out the result word it causes
    function automatic grant_t apply_event(input logic op, input logic [OWNER_W-1:0] who);
        grant_t g;
        int     s;
        g = '{slot: '0, is_target: 1'b0, code: ERR_OK};
        if (op == OP_ARRIVE) begin
            if (owner_in[who]) begin
                g.code = ERR_SEATED;
            end else begin
                // lowest free slot, -1 when every slot is taken
                s = -1;
                for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
                    if (!slot_taken[i]) s = i;
                end
                if (s < 0) begin
                    g.code = ERR_FULL;
                end else begin
                    slot_taken[s]   = 1'b1;
                    owner_in[who]   = 1'b1;
                    owner_seat[who] = s;
                    g.slot          = SLOT_OUT_W'(s);
                    g.is_target     = (who == flagged_owner);
                end
            end
        end else if (!owner_in[who]) begin
            g.code = ERR_NOT_SEATED;
        end else begin
            s             = owner_seat[who];
            slot_taken[s] = 1'b0;
            owner_in[who] = 1'b0;
            g.slot        = SLOT_OUT_W'(s);
        end
        return g;
    endfunction

    always @(posedge aclk) begin : watch_channels
        grant_t               want;
        logic [M_TDATA_W-1:0] want_data;
        if (!aresetn) begin
            // reset clears occupancy, seating and target
            for (int i = 0; i < NUM_SLOTS; i++) slot_taken[i] = 1'b0;
            for (int i = 0; i < NUM_OWNERS; i++) begin
                owner_in[i]   = 1'b0;
                owner_seat[i] = 0;
            end
            flagged_owner = '0;
            grants_due.delete();
        end else begin
            if (cfg_wr_en) flagged_owner = cfg_wr_data;

            // compare each result word with the oldest one owed
            if (m_tvalid && m_tready) begin
                if (grants_due.size() == 0) begin
                    $display("%0t: result word with nothing owed, got slot %0d flag %0d code %0d",
                             $time, m_tdata, m_tuser[0], m_tuser[2:1]);
                    fails++;
                end else begin
                    want      = grants_due.pop_front();
                    want_data = M_TDATA_W'(want.slot);
                    checked++;
                    if (m_tdata !== want_data) begin
                        $display("%0t: slot mismatch, expected %0d, got %0d",
                                 $time, want_data, m_tdata);
                        fails++;
                    end
                    if (m_tuser[0] !== want.is_target) begin
                        $display("%0t: target flag mismatch, expected %0d, got %0d",
                                 $time, want.is_target, m_tuser[0]);
                        fails++;
                    end
                    if (m_tuser[2:1] !== want.code) begin
                        $display("%0t: error code mismatch, expected %0d, got %0d",
                                 $time, want.code, m_tuser[2:1]);
                        fails++;
                    end
                end
            end

            // predict on every accepted event word
            if (s_tvalid && s_tready) begin
                want = apply_event(s_tuser[0], s_tdata[OWNER_W-1:0]);
                grants_due.push_back(want);
                if (want.is_target) flagged_hits++;
                if (want.code != ERR_OK) error_hits++;
                else if (int'(want.slot) > top_slot) top_slot = int'(want.slot);
            end
        end
        fail_count    <= fails;
        outstanding   <= grants_due.size();
        checked_count <= checked;
        target_grants <= flagged_hits;
        error_results <= error_hits;
        peak_slot     <= top_slot;
    end

endmodule

// ===== sim/lowest_free_slot_allocator_tb.sv =====
`timescale 1ns / 100ps

module lowest_free_slot_allocator_tb;
    import lfsa_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int SWEEP_COUNT = 560;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [OWNER_W-1:0]   cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;   // [9:0] owner_id, rest zero
    logic [S_TUSER_W-1:0] s_tuser     = '0;   // [0] op
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;            // [9:0] slot, rest zero
    logic [M_TUSER_W-1:0] m_tuser;            // [0] is_target, [2:1] error_code

    int fail_count;
    int outstanding;
    int checked_count;
    int target_grants;
    int error_results;
    int peak_slot;

    // who is seated, as seen from the sending side; shapes well-formed traffic
    bit                 seated_map [NUM_OWNERS];
    int                 seated_list[$];
    int                 list_pos   [NUM_OWNERS];
    logic [OWNER_W-1:0] cur_target = '0;

    bit steady        = 1'b0;
    int hold_requests = 0;
    int holds_done    = 0;
    int events_sent   = 0;
    int idle_cycles   = 0;

    lowest_free_slot_allocator dut (.*);

    slot_grant_checker grant_check (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OWNER_W-1:0] pick_unseated();
        int id;
        id = $urandom_range(0, NUM_OWNERS - 1);
        while (seated_map[id]) id = (id + 1) % NUM_OWNERS;
        return OWNER_W'(id);
    endfunction

    // offer one event word and wait for it to be taken
    task automatic send_event(input logic op, input logic [OWNER_W-1:0] who);
        int last;
        if (!steady && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(who);
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        events_sent++;
        // owners and slots are equal in number, so an arrive of an unseated owner always seats
        if (op == OP_ARRIVE && !seated_map[who]) begin
            seated_map[who] = 1'b1;
            list_pos[who]   = seated_list.size();
            seated_list.push_back(who);
        end else if (op == OP_LEAVE && seated_map[who]) begin
            last                     = seated_list[$];
            seated_list[list_pos[who]] = last;
            list_pos[last]           = list_pos[who];
            void'(seated_list.pop_back());
            seated_map[who] = 1'b0;
        end
    endtask

    // mostly well-formed arrive/leave traffic, some noise and broken sequences
    task automatic random_event(input int unsigned arrive_pct);
        logic               op;
        logic [OWNER_W-1:0] who;
        int unsigned        roll;
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            op  = 1'($urandom_range(0, 1));
            who = OWNER_W'($urandom_range(0, NUM_OWNERS - 1));
        end else if (roll < 12 && seated_list.size() > 0 && seated_list.size() < NUM_OWNERS) begin
            // arrive while seated or leave while not seated
            if ($urandom_range(0, 1) == 1) begin
                op  = OP_ARRIVE;
                who = OWNER_W'(seated_list[$urandom_range(0, seated_list.size() - 1)]);
            end else begin
                op  = OP_LEAVE;
                who = pick_unseated();
            end
        end else if (seated_list.size() < NUM_OWNERS &&
                     (seated_list.size() == 0 || $urandom_range(0, 99) < arrive_pct)) begin
            op  = OP_ARRIVE;
            who = (!seated_map[cur_target] && $urandom_range(0, 15) == 0) ?
                  cur_target : pick_unseated();
        end else begin
            op  = OP_LEAVE;
            who = OWNER_W'(seated_list[$urandom_range(0, seated_list.size() - 1)]);
        end
        send_event(op, who);
    endtask

    // stop offering and wait until every owed result word has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_target(input logic [OWNER_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        cur_target   = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // result side: random stalls, steady stretches, one long hold on request
    initial begin : result_ready_gen
        int unsigned run_len;
        logic        level;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (holds_done < hold_requests) begin
                level   = 1'b0;
                run_len = LONG_HOLD;
                holds_done++;
            end else if (steady) begin
                level   = 1'b1;
                run_len = 1;
            end else if ($urandom_range(0, 2) == 0) begin
                level   = 1'b0;
                run_len = gap_len();
            end else begin
                level   = 1'b1;
                run_len = $urandom_range(1, 12);
            end
            m_tready <= level;
            repeat (run_len) @(posedge aclk);
        end
    end

    // watchdog on words moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int order [NUM_OWNERS];
        int j;
        int t;
        int directed_count;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // leave on empty pool, grant to target 0, double arrive, lowest slot reuse
        send_event(OP_LEAVE, 10'd0);
        send_event(OP_ARRIVE, 10'd0);
        send_event(OP_ARRIVE, 10'd0);
        send_event(OP_ARRIVE, 10'd1023);
        send_event(OP_ARRIVE, 10'd512);
        send_event(OP_LEAVE, 10'd1023);
        send_event(OP_ARRIVE, 10'd341);
        send_event(OP_ARRIVE, 10'd682);
        send_event(OP_LEAVE, 10'd1023);
        send_event(OP_LEAVE, 10'd0);
        send_event(OP_ARRIVE, 10'd1023);
        send_event(OP_LEAVE, 10'd512);
        send_event(OP_LEAVE, 10'd341);
        send_event(OP_LEAVE, 10'd682);
        send_event(OP_LEAVE, 10'd1023);

        // target at the top id: flagged grant, no flag on leave or on repeat arrive
        set_target(10'd1023);
        send_event(OP_ARRIVE, 10'd1023);
        send_event(OP_ARRIVE, 10'd0);
        send_event(OP_ARRIVE, 10'd1023);
        send_event(OP_LEAVE, 10'd1023);
        send_event(OP_LEAVE, 10'd0);
        directed_count = events_sent;

        // seat a shuffled set of owners, so the low rows of the pool fill up
        set_target(OWNER_W'($urandom_range(0, NUM_OWNERS - 1)));
        for (int i = 0; i < NUM_OWNERS; i++) order[i] = i;
        for (int i = NUM_OWNERS - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < SWEEP_COUNT; i++) send_event(OP_ARRIVE, OWNER_W'(order[i]));

        // drain from a crowded pool
        set_target('0);
        repeat (80) random_event(20);

        // churn with a long result stall up front, then no idling
        set_target(OWNER_W'($urandom_range(0, NUM_OWNERS - 1)));
        hold_requests++;
        steady = 1'b1;
        repeat (60) random_event(50);
        steady = 1'b0;

        // climb back up
        set_target('1);
        repeat (50) random_event(85);

        set_target(OWNER_W'($urandom_range(0, NUM_OWNERS - 1)));
        repeat (30) random_event(50);

        settle();
        repeat (8) @(posedge aclk);

        $display("run covered %0d event words (%0d directed, %0d in the seating sweep)",
                 events_sent, directed_count, SWEEP_COUNT);
        $display("%0d results checked, %0d flagged target grants, %0d errors, top slot %0d",
                 checked_count, target_grants, error_results, peak_slot);
        if (fail_count == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
